// File: design/msbs_pkg.sv
// shared constants for the masked separable box smoother
`timescale 1ns / 1ps
package msbs_pkg;
	localparam int MAX_POINTS = 4096;
	localparam int MAX_AXIS   = 64;
	localparam int PASS_COUNT = 5;
	localparam int AXES       = 4;
	localparam int PT_W       = $clog2(MAX_POINTS);
	localparam int AX_W       = $clog2(MAX_AXIS);
	localparam int VAL_W      = 32;
	localparam int SUM_W      = 36;
	localparam int LEN_W      = 7;
	localparam int WIN_W      = 4;
	localparam int CFG_IDX_W  = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEN_BASE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_BASE = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 4'd8;

	// commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;
endpackage

// File: design/msbs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module msbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/masked_separable_box_smoother_4d.sv
// top level: grid memories, line buffer and the smoothing sequencer
//
//  channel | signals                                                  | direction
//  in      | in_valid in_ready command point_index sample_value       | into block
//          | observed last_point                                      |
//  out     | out_valid out_ready smoothed_value                       | out of block
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data                   | into block
//
// a load is written as it is taken; a read passes the read-wait state and then waits in the output register.
// a load with last_point runs 5 passes; per enabled axis and line of length L with window w:
//   start the line, fill the line buffer and step on, then per point the w window reads,
//   the sum, the restoring divider and the write back; each pass ends by restoring the
//   observed points. no input is taken while smoothing runs or a result waits.
// reset clears control state only; grid contents are undefined until loaded.
`timescale 1ns / 1ps
module masked_separable_box_smoother_4d (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [11:0] point_index,
	input  logic [31:0] sample_value,
	input  logic        observed,
	input  logic        last_point,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] smoothed_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RDWAIT = 4'd1;
	localparam logic [3:0] S_SHAPE  = 4'd2;
	localparam logic [3:0] S_AXSEL  = 4'd3;
	localparam logic [3:0] S_LSTART = 4'd4;
	localparam logic [3:0] S_LOAD   = 4'd5;
	localparam logic [3:0] S_COMP   = 4'd6;
	localparam logic [3:0] S_ACCW   = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_WB     = 4'd9;
	localparam logic [3:0] S_NLINE  = 4'd10;
	localparam logic [3:0] S_AXEND  = 4'd11;
	localparam logic [3:0] S_REST   = 4'd12;

	localparam int CNT_W = msbs_pkg::PT_W + 1;

	logic [3:0] state_q;
	logic [msbs_pkg::LEN_W-1:0] len_q [msbs_pkg::AXES];
	logic [msbs_pkg::WIN_W-1:0] win_q [msbs_pkg::AXES];
	logic [CNT_W-1:0] stride_q [msbs_pkg::AXES+1];
	logic [2:0] pass_q;
	logic [1:0] axis_q;
	logic [CNT_W-1:0] base_q, start_q, addr_q, total_q;
	logic [msbs_pkg::PT_W-1:0] j_q;
	logic [msbs_pkg::LEN_W-1:0] i_q;
	logic [msbs_pkg::WIN_W-1:0] k_q, cnt_q, dv_q, rem_q;
	logic [msbs_pkg::SUM_W-1:0] sum_q, dq_q;
	logic [5:0] dcnt_q;
	logic ld_v_s1, acc_v_s1, rs_v_s1;
	logic [msbs_pkg::AX_W-1:0] ld_idx_s1;
	logic [msbs_pkg::PT_W-1:0] rs_addr_s1;
	logic out_valid_q;
	logic [31:0] out_data_q;

	logic in_acc;
	logic [msbs_pkg::LEN_W-1:0] cur_len;
	logic [msbs_pkg::WIN_W-1:0] cur_win;
	logic [CNT_W-1:0] cur_stride, next_stride;
	logic [8:0] pos;
	logic in_range;
	logic [msbs_pkg::SUM_W-1:0] sum_nx;
	logic [msbs_pkg::WIN_W-1:0] cnt_nx;
	logic [4:0] trial;
	logic ge;
	logic [19:0] prod;
	logic [CNT_W-1:0] j_inc, nbase;

	logic wk_we;
	logic [msbs_pkg::PT_W-1:0] wk_waddr, wk_raddr;
	logic [31:0] wk_wdata, wk_rdata;
	logic [32:0] org_rdata;
	logic lb_we;
	logic [31:0] lb_rdata;

	// the last restore write lands in the final restore cycle; input is also held off while a restore write is pending
	assign in_ready       = (state_q == S_IDLE) && !out_valid_q && !rs_v_s1;
	assign in_acc         = in_valid && in_ready;
	assign out_valid      = out_valid_q;
	assign smoothed_value = out_data_q;
	assign cfg_ready      = 1'b1;

	assign cur_len     = len_q[axis_q];
	assign cur_win     = win_q[axis_q];
	assign cur_stride  = stride_q[{1'b0, axis_q}];
	assign next_stride = stride_q[{1'b0, axis_q} + 3'd1];
	// window position relative to the line start, negative shows in the top bit
	assign pos = {2'b0, i_q} + {5'b0, k_q} - {6'b0, cur_win[3:1]};
	assign in_range = !pos[8] && (pos[7:0] < {1'b0, cur_len});
	assign sum_nx = sum_q + (acc_v_s1 ? {4'b0, lb_rdata} : '0);
	assign cnt_nx = cnt_q + {3'b0, acc_v_s1};
	assign trial  = {rem_q, dq_q[msbs_pkg::SUM_W-1]};
	assign ge     = trial >= {1'b0, dv_q};
	assign prod   = 20'(total_q) * 20'(len_q[axis_q]);
	assign j_inc  = {1'b0, j_q} + 13'd1;
	assign nbase  = base_q + next_stride;

	always_comb begin
		wk_we    = 1'b0;
		wk_waddr = addr_q[msbs_pkg::PT_W-1:0];
		wk_wdata = dq_q[31:0];
		if (rs_v_s1) begin
			wk_we    = org_rdata[32];
			wk_waddr = rs_addr_s1;
			wk_wdata = org_rdata[31:0];
		end else if (state_q == S_IDLE) begin
			wk_we    = in_acc && (command == msbs_pkg::CMD_LOAD);
			wk_waddr = point_index;
			wk_wdata = sample_value;
		end else if (state_q == S_WB) begin
			wk_we = 1'b1;
		end
	end

	assign wk_raddr = (state_q == S_IDLE) ? point_index : addr_q[msbs_pkg::PT_W-1:0];
	assign lb_we    = ld_v_s1;

	msbs_ram #(.WIDTH(32), .DEPTH(msbs_pkg::MAX_POINTS)) u_work (
		.clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
		.raddr(wk_raddr), .rdata(wk_rdata)
	);

	msbs_ram #(.WIDTH(33), .DEPTH(msbs_pkg::MAX_POINTS)) u_orig (
		.clk(clk),
		.we(in_acc && (command == msbs_pkg::CMD_LOAD)),
		.waddr(point_index), .wdata({observed, sample_value}),
		.raddr(addr_q[msbs_pkg::PT_W-1:0]), .rdata(org_rdata)
	);

	msbs_ram #(.WIDTH(32), .DEPTH(msbs_pkg::MAX_AXIS)) u_line (
		.clk(clk), .we(lb_we), .waddr(ld_idx_s1), .wdata(wk_rdata),
		.raddr(pos[msbs_pkg::AX_W-1:0]), .rdata(lb_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < msbs_pkg::AXES; a++) begin
				len_q[a] <= 7'd1;
				win_q[a] <= 4'd5;
			end
		end else if (cfg_valid) begin
			if (cfg_index < msbs_pkg::REG_WIN_BASE) begin
				len_q[cfg_index[1:0]] <= cfg_data;
			end else if (cfg_index < msbs_pkg::REG_COUNT) begin
				win_q[cfg_index[1:0]] <= cfg_data[3:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RDWAIT) begin
			out_data_q <= wk_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			ld_v_s1     <= 1'b0;
			acc_v_s1    <= 1'b0;
			rs_v_s1     <= 1'b0;
			ld_idx_s1   <= '0;
			rs_addr_s1  <= '0;
			pass_q      <= '0;
			axis_q      <= '0;
			base_q      <= '0;
			start_q     <= '0;
			addr_q      <= '0;
			total_q     <= '0;
			j_q         <= '0;
			i_q         <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			dv_q        <= '0;
			rem_q       <= '0;
			sum_q       <= '0;
			dq_q        <= '0;
			dcnt_q      <= '0;
			for (int a = 0; a <= msbs_pkg::AXES; a++) begin
				stride_q[a] <= '0;
			end
		end else begin
			ld_v_s1  <= 1'b0;
			acc_v_s1 <= 1'b0;
			rs_v_s1  <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (command == msbs_pkg::CMD_READ) begin
							state_q <= S_RDWAIT;
						end else if (last_point) begin
							axis_q  <= '0;
							total_q <= 13'd1;
							state_q <= S_SHAPE;
						end
					end
				end
				S_RDWAIT: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SHAPE: begin
					// stride of each axis and the grid size, abort on a bad shape
					if (len_q[axis_q] == '0 || len_q[axis_q] > 7'(msbs_pkg::MAX_AXIS) ||
					    prod > 20'(msbs_pkg::MAX_POINTS)) begin
						state_q <= S_IDLE;
					end else begin
						stride_q[{1'b0, axis_q}] <= total_q;
						total_q <= prod[CNT_W-1:0];
						axis_q  <= axis_q + 2'd1;
						if (axis_q == 2'd3) begin
							stride_q[msbs_pkg::AXES] <= prod[CNT_W-1:0];
							pass_q  <= '0;
							state_q <= S_AXSEL;
						end
					end
				end
				S_AXSEL: begin
					base_q <= '0;
					j_q    <= '0;
					state_q <= (cur_win <= 4'd1) ? S_AXEND : S_LSTART;
				end
				S_LSTART: begin
					start_q <= base_q + {1'b0, j_q};
					addr_q  <= base_q + {1'b0, j_q};
					i_q     <= '0;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (i_q != cur_len) begin
						ld_v_s1   <= 1'b1;
						ld_idx_s1 <= i_q[msbs_pkg::AX_W-1:0];
						addr_q    <= addr_q + cur_stride;
						i_q       <= i_q + 7'd1;
					end else begin
						i_q     <= '0;
						k_q     <= '0;
						sum_q   <= '0;
						cnt_q   <= '0;
						addr_q  <= start_q;
						state_q <= S_COMP;
					end
				end
				S_COMP: begin
					sum_q    <= sum_nx;
					cnt_q    <= cnt_nx;
					acc_v_s1 <= in_range;
					k_q      <= k_q + 4'd1;
					if (k_q == cur_win - 4'd1) begin
						state_q <= S_ACCW;
					end
				end
				S_ACCW: begin
					dq_q    <= sum_nx;
					dv_q    <= cnt_nx;
					rem_q   <= '0;
					dcnt_q  <= 6'(msbs_pkg::SUM_W);
					state_q <= S_DIV;
				end
				S_DIV: begin
					// restoring divide, one quotient bit per cycle
					rem_q  <= ge ? 4'(trial - {1'b0, dv_q}) : trial[3:0];
					dq_q   <= {dq_q[msbs_pkg::SUM_W-2:0], ge};
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == 6'd1) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (i_q == cur_len - 7'd1) begin
						state_q <= S_NLINE;
					end else begin
						i_q     <= i_q + 7'd1;
						addr_q  <= addr_q + cur_stride;
						k_q     <= '0;
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_COMP;
					end
				end
				S_NLINE: begin
					if (j_inc == cur_stride) begin
						j_q    <= '0;
						base_q <= nbase;
						state_q <= (nbase >= total_q) ? S_AXEND : S_LSTART;
					end else begin
						j_q     <= j_inc[msbs_pkg::PT_W-1:0];
						state_q <= S_LSTART;
					end
				end
				S_AXEND: begin
					axis_q <= axis_q + 2'd1;
					addr_q <= '0;
					state_q <= (axis_q == 2'd3) ? S_REST : S_AXSEL;
				end
				S_REST: begin
					if (addr_q != total_q) begin
						rs_v_s1    <= 1'b1;
						rs_addr_s1 <= addr_q[msbs_pkg::PT_W-1:0];
						addr_q     <= addr_q + 13'd1;
					end else if (pass_q == 3'(msbs_pkg::PASS_COUNT - 1)) begin
						state_q <= S_IDLE;
					end else begin
						pass_q  <= pass_q + 3'd1;
						axis_q  <= '0;
						state_q <= S_AXSEL;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == S_IDLE))
		else $error("input taken outside idle");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (dv_q != '0))
		else $error("divide by zero count");
	// the last fill write lands in the final load-state cycle, before the window reads
	a_lb_fill: assert property (@(posedge clk) disable iff (!arst_n)
		lb_we |-> (state_q == S_LOAD || state_q == S_COMP))
		else $error("line buffer written outside fill");
	a_comp_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP) |-> (i_q < cur_len))
		else $error("point index beyond line");
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDWAIT) |=> out_valid)
		else $error("read result missing");
endmodule

// File: sim/tb_masked_separable_box_smoother_4d.sv
// testbench for the masked separable box smoother: directed and random grids checked against a local predictor
`timescale 1ns / 1ps
module tb_masked_separable_box_smoother_4d;
	localparam int LIMIT_CYCLES = 8000000;
	localparam int HOLD_CYCLES  = 500;
	localparam int DRAIN_WAIT   = 60;

	typedef struct packed {
		logic        cmd;
		logic [11:0] idx;
		logic [31:0] val;
		logic        obs;
		logic        last;
	} grid_op_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = msbs_pkg::CMD_LOAD;
	logic [11:0] point_index = '0;
	logic [31:0] sample_value = '0;
	logic        observed = 1'b0;
	logic        last_point = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] smoothed_value;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	masked_separable_box_smoother_4d dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.point_index(point_index), .sample_value(sample_value),
		.observed(observed), .last_point(last_point),
		.out_valid(out_valid), .out_ready(out_ready), .smoothed_value(smoothed_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [31:0] work_mem [msbs_pkg::MAX_POINTS];
	logic [31:0] orig_mem [msbs_pkg::MAX_POINTS];
	bit          keep_mem [msbs_pkg::MAX_POINTS];
	logic [6:0]  axis_len [msbs_pkg::AXES];
	logic [3:0]  axis_win [msbs_pkg::AXES];

	grid_op_t    pending_ops [$];
	logic [31:0] expected_values [$];
	grid_op_t    cur_op;
	int          errors = 0;
	int          send_idle = 0;
	int          recv_idle = 0;
	bit          hold_go = 1'b0;
	int          hold_cnt = 0;
	logic        holding;
	longint      cycles = 0;

	// written indexes, so reads never touch an unloaded entry
	bit          loaded [msbs_pkg::MAX_POINTS];
	int          loaded_list [$];
	int          made = 0;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void mean_line(int unsigned start, int unsigned strd, int unsigned len,
			int unsigned win);
		logic [31:0] line [msbs_pkg::MAX_AXIS];
		int unsigned half;
		int unsigned pos;
		int unsigned cnt;
		logic [35:0] acc;
		half = win / 2;
		for (int unsigned i = 0; i < len; i++)
			line[i] = work_mem[start + i * strd];
		for (int unsigned i = 0; i < len; i++) begin
			acc = '0;
			cnt = 0;
			for (int unsigned k = 0; k < win; k++) begin
				pos = i + k;
				if (pos >= half && pos - half < len) begin
					acc += line[pos - half];
					cnt++;
				end
			end
			if (cnt == 0)
				cnt = 1;
			work_mem[start + i * strd] = 32'(acc / cnt);
		end
	endfunction

	function automatic void smooth_grid();
		int unsigned strd [msbs_pkg::AXES];
		int unsigned tot;
		tot = 1;
		for (int a = 0; a < msbs_pkg::AXES; a++) begin
			if (axis_len[a] == 0 || axis_len[a] > msbs_pkg::MAX_AXIS)
				return;
			strd[a] = tot;
			tot *= axis_len[a];
			if (tot > msbs_pkg::MAX_POINTS)
				return;
		end
		for (int pass = 0; pass < msbs_pkg::PASS_COUNT; pass++) begin
			for (int a = 0; a < msbs_pkg::AXES; a++) begin
				if (axis_win[a] <= 1)
					continue;
				for (int unsigned p = 0; p < tot; p++)
					if ((p / strd[a]) % axis_len[a] == 0)
						mean_line(p, strd[a], axis_len[a], axis_win[a]);
			end
			for (int unsigned p = 0; p < tot; p++)
				if (keep_mem[p])
					work_mem[p] = orig_mem[p];
		end
	endfunction

	function automatic void predict_op(grid_op_t op);
		if (op.cmd == msbs_pkg::CMD_READ) begin
			expected_values.push_back(work_mem[op.idx]);
		end else begin
			work_mem[op.idx] = op.val;
			orig_mem[op.idx] = op.val;
			keep_mem[op.idx] = op.obs;
			if (op.last)
				smooth_grid();
		end
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_op(cur_op);
			if ((in_valid && in_ready) || !in_valid) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle) begin
					cur_op = pending_ops.pop_front();
					in_valid <= 1'b1;
					command <= cur_op.cmd;
					point_index <= cur_op.idx;
					sample_value <= cur_op.val;
					observed <= cur_op.obs;
					last_point <= cur_op.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk)
		if (hold_go && hold_cnt < HOLD_CYCLES)
			hold_cnt <= hold_cnt + 1;
	assign holding = hold_go && hold_cnt < HOLD_CYCLES;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !holding && ($urandom_range(99) >= recv_idle);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_values.size() == 0) begin
				report("unexpected result", smoothed_value, 32'h0);
			end else begin
				logic [31:0] want;
				want = expected_values.pop_front();
				if (smoothed_value !== want)
					report("smoothed_value", smoothed_value, want);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic cfg_write(logic [3:0] idx, logic [6:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx < msbs_pkg::REG_WIN_BASE)
			axis_len[idx - msbs_pkg::REG_LEN_BASE] = data;
		else if (idx < msbs_pkg::REG_COUNT)
			axis_win[idx - msbs_pkg::REG_WIN_BASE] = data[3:0];
	endtask

	task automatic set_shape(int l1, int l2, int l3, int l4, int w1, int w2, int w3, int w4);
		cfg_write(msbs_pkg::REG_LEN_BASE + 4'd0, 7'(l1));
		cfg_write(msbs_pkg::REG_LEN_BASE + 4'd1, 7'(l2));
		cfg_write(msbs_pkg::REG_LEN_BASE + 4'd2, 7'(l3));
		cfg_write(msbs_pkg::REG_LEN_BASE + 4'd3, 7'(l4));
		cfg_write(msbs_pkg::REG_WIN_BASE + 4'd0, 7'(w1));
		cfg_write(msbs_pkg::REG_WIN_BASE + 4'd1, 7'(w2));
		cfg_write(msbs_pkg::REG_WIN_BASE + 4'd2, 7'(w3));
		cfg_write(msbs_pkg::REG_WIN_BASE + 4'd3, 7'(w4));
	endtask

	task automatic push_load(int idx, logic [31:0] val, logic obs, logic last);
		pending_ops.push_back('{msbs_pkg::CMD_LOAD, 12'(idx), val, obs, last});
		if (!loaded[idx]) begin
			loaded[idx] = 1'b1;
			loaded_list.push_back(idx);
		end
		made++;
	endtask

	task automatic push_read(int idx);
		pending_ops.push_back('{msbs_pkg::CMD_READ, 12'(idx), $urandom, 1'($urandom),
			1'($urandom)});
		made++;
	endtask

	// wait until the block is idle before touching registers
	task automatic drain();
		while (pending_ops.size() > 0 || in_valid || expected_values.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_amp();
		case ($urandom_range(3))
			0: return 32'($urandom_range(0, 255)) << 16;
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	// loads every point of the grid in shuffled order with stray loads and reads mixed in, last one starts smoothing
	task automatic load_grid(int tot);
		int order [$];
		for (int i = 0; i < tot; i++)
			order.push_back(i);
		order.shuffle();
		foreach (order[i]) begin
			if (i > 0 && $urandom_range(7) == 0)
				push_read(loaded_list[$urandom_range(loaded_list.size() - 1)]);
			if ($urandom_range(9) == 0)
				push_load($urandom_range(msbs_pkg::MAX_POINTS - 1), rand_amp(),
					1'($urandom), 1'b0);
			push_load(order[i], rand_amp(), 1'($urandom), i == tot - 1);
		end
	endtask

	initial begin
		int l [msbs_pkg::AXES];
		int w [msbs_pkg::AXES];
		int tot;
		int nreads;
		for (int a = 0; a < msbs_pkg::AXES; a++) begin
			axis_len[a] = 7'd1;
			axis_win[a] = 4'd5;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, single point
		push_load(0, 32'hFFFF_FFFF, 1'b0, 1'b1);
		push_read(0);
		drain();

		// mixed windows: wide, off, one, two
		set_shape(4, 2, 1, 1, 15, 0, 1, 2);
		push_load(0, 32'h0, 1'b0, 1'b0);
		push_load(1, 32'hFFFF_FFFF, 1'b1, 1'b0);
		push_load(2, 32'h0000_0001, 1'b0, 1'b0);
		push_load(3, 32'h8000_0000, 1'b0, 1'b0);
		push_load(4, 32'hFFFF_FFFF, 1'b0, 1'b0);
		push_load(5, 32'h0, 1'b1, 1'b0);
		push_load(6, 32'h7FFF_FFFF, 1'b0, 1'b0);
		push_load(7, 32'h0001_0000, 1'b0, 1'b1);
		for (int i = 0; i < 8; i++)
			push_read(i);
		push_load(4095, 32'hA5A5_5A5A, 1'b1, 1'b0);
		push_read(4095);
		drain();

		// unknown register indexes are ignored
		cfg_write(msbs_pkg::REG_COUNT, 7'h7F);
		cfg_write(4'hF, 7'h7F);
		// bad shapes: zero length, oversize length, too many points
		cfg_write(msbs_pkg::REG_LEN_BASE + 4'd1, 7'd0);
		push_load(2, 32'h1234_5678, 1'b0, 1'b1);
		push_read(2);
		drain();
		set_shape(127, 1, 1, 1, 3, 3, 3, 3);
		push_load(1, 32'hDEAD_BEEF, 1'b0, 1'b1);
		push_read(1);
		drain();
		set_shape(64, 64, 2, 1, 15, 15, 15, 15);
		push_load(3, 32'h0F0F_0F0F, 1'b0, 1'b1);
		push_read(3);
		drain();

		// longest line, widest windows
		set_shape(64, 1, 1, 1, 15, 15, 15, 15);
		load_grid(64);
		for (int i = 0; i < 10; i++)
			push_read($urandom_range(63));
		drain();

		while (made < 1750) begin
			if (made < 600) begin
				send_idle = 31;
				recv_idle = 54;
			end else if (made < 1200) begin
				send_idle = 54;
				recv_idle = 31;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int a = 0; a < msbs_pkg::AXES; a++)
				w[a] = $urandom_range(0, 15);
			if ($urandom_range(19) == 0) begin
				for (int a = 0; a < msbs_pkg::AXES; a++)
					l[a] = $urandom_range(1, 4);
				case ($urandom_range(2))
					0: l[$urandom_range(3)] = 0;
					1: l[$urandom_range(3)] = $urandom_range(65, 127);
					default: begin
						l[0] = 64;
						l[1] = 64;
						l[2] = $urandom_range(2, 64);
					end
				endcase
				set_shape(l[0], l[1], l[2], l[3], w[0], w[1], w[2], w[3]);
				push_load($urandom_range(msbs_pkg::MAX_POINTS - 1), rand_amp(),
					1'($urandom), 1'b1);
				for (int i = 0; i < 4; i++)
					push_read(loaded_list[$urandom_range(loaded_list.size() - 1)]);
			end else begin
				do begin
					if ($urandom_range(7) == 0) begin
						l = '{1, 1, 1, 1};
						l[$urandom_range(3)] = $urandom_range(1, 16);
					end else begin
						for (int a = 0; a < msbs_pkg::AXES; a++)
							l[a] = $urandom_range(1, 4);
					end
					tot = l[0] * l[1] * l[2] * l[3];
				end while (tot > 16);
				set_shape(l[0], l[1], l[2], l[3], w[0], w[1], w[2], w[3]);
				if (!hold_go && made > 700) begin
					// stall the output so the block backs up its input
					hold_go = 1'b1;
					nreads = 30;
				end else begin
					nreads = $urandom_range(tot, 2 * tot + 4);
				end
				load_grid(tot);
				for (int i = 0; i < nreads; i++)
					push_read($urandom_range(3) == 0 ?
						loaded_list[$urandom_range(loaded_list.size() - 1)] :
						$urandom_range(tot - 1));
				// sometimes touch up one point and smooth again
				if ($urandom_range(3) == 0) begin
					push_load($urandom_range(tot - 1), rand_amp(), 1'($urandom), 1'b1);
					for (int i = 0; i < 3; i++)
						push_read($urandom_range(tot - 1));
				end
			end
			drain();
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// File: masked_separable_box_smoother_4d.f
design/msbs_pkg.sv
design/msbs_ram.sv
design/masked_separable_box_smoother_4d.sv
sim/tb_masked_separable_box_smoother_4d.sv
